// ----- rtl/sbe_pkg.sv -----
// sbe_pkg: opcodes, status codes and controller/datapath interface types
// for the stack bytecode executor; no dependencies
package sbe_pkg;

  // bytecode opcodes
  localparam logic [7:0] OP_PUSH = 8'h10;
  localparam logic [7:0] OP_MUL  = 8'h68;
  localparam logic [7:0] OP_DIV  = 8'h6c;
  localparam logic [7:0] OP_ADD  = 8'h60;
  localparam logic [7:0] OP_SUB  = 8'h64;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNDER   = 3'd1;
  localparam logic [2:0] ST_OVER    = 3'd2;
  localparam logic [2:0] ST_DIVZERO = 3'd3;
  localparam logic [2:0] ST_TRUNC   = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;

  localparam int WORD_W = 32;

  // commands from controller to datapath
  typedef struct packed {
    logic       latch;
    logic       set_pend;
    logic       clr_pend;
    logic       push;
    logic       rd_second;
    logic       arith_wr;
    logic       div_start;
    logic       div_wr;
    logic       note_err;
    logic [2:0] err_code;
    logic       load_out;
    logic       clr_err;
  } sbe_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic pend;
    logic is_push;
    logic is_arith;
    logic is_div;
    logic last;
    logic cnt_lt2;
    logic cnt_full;
    logic top_zero;
    logic div_done;
  } sbe_stat_t;

endpackage

// ----- rtl/sbe_div.sv -----
// sbe_div: iterative 32-bit signed divider, one quotient bit per cycle
// depends on sbe_pkg
module sbe_div
  import sbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] num,
  input  logic [WORD_W-1:0] den,
  output logic              done,
  output logic [WORD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(WORD_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic              negq;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] dmag;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   trial;

  // restoring step: shift in next dividend bit, try subtracting divisor
  assign shifted = {rem, quo[WORD_W-1]};
  assign trial   = shifted - {1'b0, dmag};

  // control: busy flag, step counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operand magnitudes and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      negq <= num[WORD_W-1] ^ den[WORD_W-1];
      quo  <= num[WORD_W-1] ? (~num + 1'b1) : num;
      dmag <= den[WORD_W-1] ? (~den + 1'b1) : den;
      rem  <= '0;
    end else if (busy) begin
      quo <= {quo[WORD_W-2:0], ~trial[WORD_W]};
      rem <= trial[WORD_W] ? shifted[WORD_W-1:0] : trial[WORD_W-1:0];
    end
  end

  // sign fix; the most negative over minus one wraps by itself
  assign quotient = negq ? (~quo + 1'b1) : quo;

endmodule

// ----- rtl/sbe_ctrl.sv -----
// sbe_ctrl: sequencing state machine for the stack bytecode executor
// depends on sbe_pkg
module sbe_ctrl
  import sbe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  sbe_stat_t stat,
  output sbe_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_CALC   = 5'b00100,
    S_DIVW   = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   m_tvalid_next;
  state_t state_end;

  // after an item's work: report on the last byte, else wait for more
  assign state_end = stat.last ? S_EMIT : S_IDLE;
  assign s_tready  = (state == S_IDLE);

  // next state and commands
  always_comb begin
    cmd           = '0;
    state_next    = state;
    m_tvalid_next = m_tvalid & ~m_tready;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = state_end;
        if (stat.pend) begin
          cmd.clr_pend = 1'b1;
          if (stat.cnt_full) begin
            cmd.note_err = 1'b1;
            cmd.err_code = ST_OVER;
          end else begin
            cmd.push = 1'b1;
          end
        end else if (stat.is_push) begin
          if (stat.last) begin
            cmd.note_err = 1'b1;
            cmd.err_code = ST_TRUNC;
          end else begin
            cmd.set_pend = 1'b1;
          end
        end else if (stat.is_arith) begin
          if (stat.cnt_lt2) begin
            cmd.note_err = 1'b1;
            cmd.err_code = ST_UNDER;
          end else begin
            cmd.rd_second = 1'b1;
            state_next    = S_CALC;
          end
        end
      end
      S_CALC: begin
        state_next = state_end;
        if (!stat.is_div) begin
          cmd.arith_wr = 1'b1;
        end else if (stat.top_zero) begin
          cmd.note_err = 1'b1;
          cmd.err_code = ST_DIVZERO;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIVW;
        end
      end
      S_DIVW: begin
        if (stat.div_done) begin
          cmd.div_wr = 1'b1;
          state_next = state_end;
        end
      end
      S_EMIT: begin
        if (!m_tvalid || m_tready) begin
          cmd.load_out  = 1'b1;
          cmd.clr_err   = 1'b1;
          cmd.clr_pend  = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

// ----- rtl/sbe_dpath.sv -----
// sbe_dpath: operand stack memory, top-of-stack register, alu, divider
// and result register; depends on sbe_pkg and sbe_div
module sbe_dpath
  import sbe_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        code_byte,
  input  logic              last_byte,
  input  sbe_cmd_t          cmd,
  output sbe_stat_t         stat,
  output logic [WORD_W-1:0] top_value,
  output logic [2:0]        status
);

  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  // entries below the top live in memory, the top in a register
  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] top;
  logic [WORD_W-1:0] second;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic              pending;
  logic [2:0]        first_err;
  logic [7:0]        byte_q;
  logic              last_q;
  logic [WORD_W-1:0] alu_res;
  logic              div_done;
  logic [WORD_W-1:0] div_quo;

  assign cnt_m1 = count - 1'b1;
  assign cnt_m2 = count - 2'd2;

  // latched input item
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      byte_q <= code_byte;
      last_q <= last_byte;
    end
  end

  // stack memory: spill old top on push, read second entry for an op
  always_ff @(posedge clk) begin
    if (cmd.push && count != '0) begin
      mem[cnt_m1[AW-1:0]] <= top;
    end
    if (cmd.rd_second) begin
      second <= mem[cnt_m2[AW-1:0]];
    end
  end

  // add, subtract, multiply (low word)
  always_comb begin
    case (byte_q)
      OP_MUL:  alu_res = top * second;
      OP_SUB:  alu_res = second - top;
      default: alu_res = top + second;
    endcase
  end

  sbe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .num      (second),
    .den      (top),
    .done     (div_done),
    .quotient (div_quo)
  );

  // top of stack register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top <= {{(WORD_W-8){1'b0}}, byte_q};
    end else if (cmd.arith_wr) begin
      top <= alu_res;
    end else if (cmd.div_wr) begin
      top <= div_quo;
    end
  end

  // stack count, push pending flag, first error of the program
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pending   <= 1'b0;
      first_err <= ST_OK;
    end else begin
      if (cmd.push) begin
        count <= count + 1'b1;
      end else if (cmd.arith_wr || cmd.div_wr) begin
        count <= cnt_m1;
      end
      if (cmd.set_pend) begin
        pending <= 1'b1;
      end else if (cmd.clr_pend) begin
        pending <= 1'b0;
      end
      if (cmd.clr_err) begin
        first_err <= ST_OK;
      end else if (cmd.note_err && first_err == ST_OK) begin
        first_err <= cmd.err_code;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (count == '0) begin
        top_value <= '0;
        status    <= (first_err == ST_OK) ? ST_EMPTY : first_err;
      end else begin
        top_value <= top;
        status    <= first_err;
      end
    end
  end

  // status towards the controller
  always_comb begin
    stat.pend     = pending;
    stat.is_push  = (byte_q == OP_PUSH);
    stat.is_arith = (byte_q == OP_MUL) || (byte_q == OP_ADD) ||
                    (byte_q == OP_SUB) || (byte_q == OP_DIV);
    stat.is_div   = (byte_q == OP_DIV);
    stat.last     = last_q;
    stat.cnt_lt2  = (count < CNT_W'(2));
    stat.cnt_full = (count == CNT_W'(STACK_DEPTH));
    stat.top_zero = (top == '0);
    stat.div_done = div_done;
  end

endmodule

// ----- rtl/stack_bytecode_executor.sv -----
// stack_bytecode_executor: runs integer stack bytecode one byte per item
// one item at a time: push, operand, skipped or failing byte pass idle and decode; add,
// sub, mul and divide by zero add the calc state; divide also waits in the divider state
// a last byte adds the emit state to load the result, held there while a result waits on m_tready
// sync active-high reset clears stack count, pending push, error and output valid;
// stack contents are not cleared
module stack_bytecode_executor
  import sbe_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] code_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [31:0] top_value, [34:32] status, rest zero
);

  sbe_cmd_t          cmd;
  sbe_stat_t         stat;
  logic [WORD_W-1:0] top_value;
  logic [2:0]        status;

  sbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sbe_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .code_byte (s_tdata),
    .last_byte (s_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .top_value (top_value),
    .status    (status)
  );

  // pack result item
  assign m_tdata = {5'b0, status, top_value};

endmodule
